/* hw/rtl/wcsa_pkg.sv */
// Shared constants, codes and controller/datapath interface types.
package wcsa_pkg;

	localparam int MAX_ITEMS    = 16;
	localparam int MAX_CATS     = 8;
	localparam int MAX_SCORES   = 32;
	localparam int SLOT_TOTAL   = MAX_ITEMS * MAX_CATS;
	localparam int SLOT_W       = $clog2(SLOT_TOTAL);
	localparam int USED_W       = $clog2(SLOT_TOTAL + 1);
	localparam int SCORE_W      = (MAX_SCORES > 1) ? $clog2(MAX_SCORES) : 1;
	localparam int DESIGN_DEPTH = SLOT_TOTAL * MAX_SCORES;
	localparam int DADDR_W      = $clog2(DESIGN_DEPTH);
	localparam int SUM_W        = 48;
	localparam int ACC_W        = 64;
	localparam int COEF_W       = 16;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 8;

	typedef enum logic [1:0] {
		OP_OBS  = 2'd0,
		OP_LOAD = 2'd1,
		OP_FIN  = 2'd2,
		OP_NOP  = 2'd3
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CATS   = 2'd0,
		REG_ITEMS  = 2'd1,
		REG_SCORES = 2'd2,
		REG_NONE   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic               capture;   // latch input fields
		logic               obs_rd;    // read slot sum for observation
		logic               obs_wr;    // write back observation
		logic               load_wr;   // write design entry
		logic               issue;     // issue one dot-product term
		logic [SLOT_W-1:0]  h;
		logic [SCORE_W-1:0] p;
		logic               first;
		logic               last;
		logic               term;
		logic               clr_sums;  // end of batch
		logic               dclr;      // design store clearing pass
		logic [DADDR_W-1:0] dclr_addr;
	} ctl_cmd_t;

	typedef struct packed {
		logic [USED_W-1:0]  used;
		logic [SCORE_W-1:0] n_last;
		logic               pipe_busy;
	} ctl_stat_t;

endpackage

/* hw/rtl/wcsa_ctrl.sv */
// Controller: clearing pass, item dispatch and finish sequencing.
module wcsa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          opcode,
	input  logic                observed,
	input  wcsa_pkg::ctl_stat_t stat,
	output logic                busy,
	output wcsa_pkg::ctl_cmd_t  cmd
);
	import wcsa_pkg::*;

	typedef enum logic [2:0] {
		ST_CLR, ST_IDLE, ST_OBS_RD, ST_OBS_WR, ST_LOAD, ST_FIN, ST_DRAIN
	} state_t;

	state_t              state_q;
	logic [DADDR_W-1:0]  clr_q;
	logic [SLOT_W-1:0]   h_q;
	logic [SCORE_W-1:0]  p_q;
	logic                term_c, last_c, accept_c;

	assign busy     = (state_q != ST_IDLE);
	assign accept_c = start && !busy;
	assign term_c   = (stat.used != '0);
	assign last_c   = term_c ? ((USED_W'(h_q) + USED_W'(1)) == stat.used) : 1'b1;

	always_comb begin
		cmd           = '0;
		cmd.capture   = accept_c;
		cmd.obs_rd    = (state_q == ST_OBS_RD);
		cmd.obs_wr    = (state_q == ST_OBS_WR);
		cmd.load_wr   = (state_q == ST_LOAD);
		cmd.issue     = (state_q == ST_FIN);
		cmd.h         = h_q;
		cmd.p         = p_q;
		cmd.first     = (h_q == '0);
		cmd.last      = last_c;
		cmd.term      = term_c;
		cmd.clr_sums  = (state_q == ST_DRAIN) && !stat.pipe_busy;
		cmd.dclr      = (state_q == ST_CLR);
		cmd.dclr_addr = clr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			h_q     <= '0;
			p_q     <= '0;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + DADDR_W'(1);
					if (clr_q == DADDR_W'(DESIGN_DEPTH - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept_c) begin
						h_q <= '0;
						p_q <= '0;
						unique case (opcode_t'(opcode))
							OP_OBS:  state_q <= observed ? ST_OBS_RD : ST_IDLE;
							OP_LOAD: state_q <= ST_LOAD;
							OP_FIN:  state_q <= ST_FIN;
							OP_NOP:  state_q <= ST_IDLE;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_OBS_RD: state_q <= ST_OBS_WR;
				ST_OBS_WR: state_q <= ST_IDLE;
				ST_LOAD:   state_q <= ST_IDLE;
				ST_FIN: begin
					if (last_c) begin
						h_q <= '0;
						if (p_q == stat.n_last)
							state_q <= ST_DRAIN;
						else
							p_q <= p_q + SCORE_W'(1);
					end else begin
						h_q <= h_q + SLOT_W'(1);
					end
				end
				ST_DRAIN: begin
					if (!stat.pipe_busy)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* hw/rtl/wcsa_dp.sv */
// Datapath: configuration, slot-sum and design stores, multiply-accumulate pipe.
module wcsa_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  wcsa_pkg::ctl_cmd_t  cmd,
	output wcsa_pkg::ctl_stat_t stat,
	input  logic                cfg_valid,
	input  logic [wcsa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wcsa_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                observed,
	input  logic [3:0]          item_index,
	input  logic [2:0]          category,
	input  logic [31:0]         weight,
	input  logic [6:0]          slot,
	input  logic [4:0]          column,
	input  logic signed [15:0]  coefficient,
	output logic                strobe,
	output logic [4:0]          score_index,
	output logic signed [63:0]  score,
	output logic                last,
	output logic                dropped_seen
);
	import wcsa_pkg::*;

	logic [3:0] cats_q;
	logic [4:0] items_q;
	logic [5:0] scores_q;

	logic [3:0] cats_eff;
	logic [4:0] items_eff;
	logic [5:0] n_eff;

	// captured item
	logic               observed_q;
	logic [3:0]         item_q;
	logic [2:0]         cat_q;
	logic [31:0]        weight_q;
	logic [6:0]         slot_q;
	logic [4:0]         column_q;
	logic signed [15:0] coef_q;

	logic [SUM_W-1:0]   sum_mem [SLOT_TOTAL];
	logic [SLOT_TOTAL-1:0] slot_vld_q;
	logic signed [COEF_W-1:0] design_mem [DESIGN_DEPTH];
	logic               dropped_q;

	logic               obs_ok;
	logic [SLOT_W-1:0]  h_obs, rd_h;
	logic [SUM_W:0]     obs_sum;

	// pipe
	logic               v_s1, first_s1, last_s1, term_s1, vld_s1;
	logic [SCORE_W-1:0] p_s1;
	logic [SUM_W-1:0]   sum_s1;
	logic signed [COEF_W-1:0] coef_s1;
	logic               v_s2, first_s2, last_s2;
	logic [SCORE_W-1:0] p_s2;
	logic signed [ACC_W-1:0] prod_s2;
	logic signed [ACC_W-1:0] acc_q;

	logic signed [SUM_W:0]   sum_ext;
	logic signed [ACC_W:0]   mul_c;
	logic signed [ACC_W-1:0] base_c, acc_c;
	logic signed [ACC_W:0]   add_c;

	assign cats_eff  = (cats_q > 4'(MAX_CATS)) ? 4'(MAX_CATS) : cats_q;
	assign items_eff = (items_q > 5'(MAX_ITEMS)) ? 5'(MAX_ITEMS) : items_q;
	always_comb begin
		priority if (scores_q == '0)               n_eff = 6'd1;
		else if (scores_q > 6'(MAX_SCORES))        n_eff = 6'(MAX_SCORES);
		else                                       n_eff = scores_q;
	end

	assign stat.used      = USED_W'(items_eff) * USED_W'(cats_eff);
	assign stat.n_last    = SCORE_W'(n_eff - 6'd1);
	assign stat.pipe_busy = v_s1 || v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cats_q   <= 4'(MAX_CATS);
			items_q  <= 5'(MAX_ITEMS);
			scores_q <= 6'(MAX_SCORES);
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CATS:   cats_q   <= cfg_data[3:0];
				REG_ITEMS:  items_q  <= cfg_data[4:0];
				REG_SCORES: scores_q <= cfg_data[5:0];
				REG_NONE:   ;
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			observed_q <= observed;
			item_q     <= item_index;
			cat_q      <= category;
			weight_q   <= weight;
			slot_q     <= slot;
			column_q   <= column;
			coef_q     <= coefficient;
		end
	end

	assign obs_ok  = ({1'b0, item_q} < items_eff) && ({1'b0, cat_q} < cats_eff);
	assign h_obs   = SLOT_W'(item_q) * SLOT_W'(cats_eff) + SLOT_W'(cat_q);
	assign rd_h    = cmd.obs_rd ? h_obs : cmd.h;
	assign obs_sum = {1'b0, vld_s1 ? sum_s1 : SUM_W'(0)} + (SUM_W+1)'(weight_q);

	// slot sums: one read and one write port, valid bits stand for the zero reset
	always_ff @(posedge clk) begin
		sum_s1 <= sum_mem[rd_h];
		if (cmd.obs_wr && observed_q && obs_ok)
			sum_mem[h_obs] <= obs_sum[SUM_W] ? {SUM_W{1'b1}} : obs_sum[SUM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_vld_q <= '0;
			vld_s1     <= 1'b0;
			dropped_q  <= 1'b0;
		end else begin
			vld_s1 <= slot_vld_q[rd_h];
			if (cmd.clr_sums) begin
				slot_vld_q <= '0;
				dropped_q  <= 1'b0;
			end else if (cmd.obs_wr && observed_q) begin
				if (obs_ok)
					slot_vld_q[h_obs] <= 1'b1;
				else
					dropped_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		coef_s1 <= design_mem[DADDR_W'(cmd.h * MAX_SCORES + cmd.p)];
		if (cmd.dclr)
			design_mem[cmd.dclr_addr] <= '0;
		else if (cmd.load_wr && ({1'b0, slot_q} < 8'(SLOT_TOTAL))
			&& ({1'b0, column_q} < 6'(MAX_SCORES)))
			design_mem[DADDR_W'(slot_q * MAX_SCORES + column_q)] <= coef_q;
	end

	// stage 1 tokens, stage 2 product, then accumulate
	assign sum_ext = $signed({1'b0, (vld_s1 && term_s1) ? sum_s1 : SUM_W'(0)});
	assign mul_c   = sum_ext * coef_s1;
	assign base_c  = first_s2 ? '0 : acc_q;
	assign add_c   = {base_c[ACC_W-1], base_c} + {prod_s2[ACC_W-1], prod_s2};
	always_comb begin
		if (add_c[ACC_W] != add_c[ACC_W-1])
			acc_c = add_c[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		else
			acc_c = add_c[ACC_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			strobe <= 1'b0;
			last   <= 1'b0;
		end else begin
			v_s1   <= cmd.issue;
			v_s2   <= v_s1;
			strobe <= v_s2 && last_s2;
			last   <= v_s2 && last_s2 && (p_s2 == stat.n_last);
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= cmd.first;
		last_s1  <= cmd.last;
		term_s1  <= cmd.term;
		p_s1     <= cmd.p;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		p_s2     <= p_s1;
		prod_s2  <= mul_c[ACC_W-1:0];
		if (v_s2) begin
			acc_q <= acc_c;
			if (last_s2) begin
				score        <= acc_c;
				score_index  <= 5'(p_s2);
				dropped_seen <= dropped_q;
			end
		end
	end

endmodule

/* hw/rtl/weighted_category_score_accumulator.sv */
// Top level: weighted category score accumulator.
//
// channel  signals                                   transaction
// input    start, busy, opcode .. coefficient        start && !busy
// config   cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid && cfg_ready
// result   strobe, score_index, score, last, dropped strobe, one cycle each
//
// Observation (when observed is set): slot-sum read, then write-back; load: one design-store write.
// Finish: one term per cycle over max(1, items*cats) terms per score, times the score
// count, then a drain state until the multiply-accumulate pipe is empty.
// After reset the design store is cleared, one entry a cycle, all 4096 entries, with busy high.
// Config writes are always taken; the result side cannot stall.
module weighted_category_score_accumulator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         opcode,
	input  logic               observed,
	input  logic [3:0]         item_index,
	input  logic [2:0]         category,
	input  logic [31:0]        weight,
	input  logic [6:0]         slot,
	input  logic [4:0]         column,
	input  logic signed [15:0] coefficient,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [wcsa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wcsa_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic               strobe,
	output logic [4:0]         score_index,
	output logic signed [63:0] score,
	output logic               last,
	output logic               dropped_seen
);
	import wcsa_pkg::*;

	ctl_cmd_t  cmd;
	ctl_stat_t stat;

	assign cfg_ready = 1'b1;

	wcsa_ctrl u_ctrl (
		.clk, .arst_n, .start, .opcode, .observed, .stat, .busy, .cmd
	);

	wcsa_dp u_dp (
		.clk, .arst_n, .cmd, .stat,
		.cfg_valid(cfg_valid && cfg_ready), .cfg_index, .cfg_data,
		.observed, .item_index, .category, .weight, .slot, .column,
		.coefficient, .strobe, .score_index, .score, .last, .dropped_seen
	);

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy) else $error("result outside a finish");
	a_last_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> strobe) else $error("last without result");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe) else $error("result after last");

endmodule
